### rtl/core/mpfu_pkg.sv
`timescale 1ns / 1ps
// shared types, register indexes and limits for the masked pixel format unpacker
// no dependencies

package mpfu_pkg;

    localparam int MAX_WIDTH = 4096;
    localparam logic [12:0] MAX_WIDTH_W = 13'(MAX_WIDTH);

    localparam int ADDR_W = 5;

    localparam logic [2:0] REG_BYTES_PER_PIXEL = 3'd0;
    localparam logic [2:0] REG_ROW_WIDTH       = 3'd1;
    localparam logic [2:0] REG_ROW_PADDING     = 3'd2;
    localparam logic [2:0] REG_RED_MASK        = 3'd3;
    localparam logic [2:0] REG_GREEN_MASK      = 3'd4;
    localparam logic [2:0] REG_BLUE_MASK       = 3'd5;
    localparam logic [2:0] REG_ALPHA_MASK      = 3'd6;
    localparam logic [2:0] REG_CHANNEL_SHIFTS  = 3'd7;

    localparam logic [7:0] ALPHA_OPAQUE = 8'd255;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       first_of_frame;
    } t_in_item;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
        logic       end_of_row;
    } t_out_item;

    typedef struct packed {
        logic [2:0]  bytes_per_pixel;
        logic [12:0] row_width;
        logic [7:0]  row_padding;
        logic [31:0] red_mask;
        logic [31:0] green_mask;
        logic [31:0] blue_mask;
        logic [31:0] alpha_mask;
        logic [19:0] channel_shifts;
    } t_cfg;

    // one assembled pixel waiting for channel extraction
    typedef struct packed {
        logic [31:0] word;
        logic        mono;
        logic        quad;
        logic        end_of_row;
    } t_job;

endpackage

### rtl/core/masked_pixel_format_unpacker_core.sv
`timescale 1ns / 1ps
// Byte-stream to RGBA unpacker. One raster byte is taken per cycle while the
// pixel queue has room; a pixel of 1 to 4 little-endian bytes is queued as its
// last byte is taken and then moves into the output register; padding bytes
// after each row are consumed without a result. The two-entry queue sits between
// byte assembly and channel extraction, so input keeps flowing for two pixels
// while output is stalled; after that input ready drops until the output drains.
// Configuration is an APB-style port, registers at byte addresses 4*i.
// depends on mpfu_pkg, mpfu_regs, mpfu_front, mpfu_fifo, mpfu_back

module masked_pixel_format_unpacker_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [mpfu_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  mpfu_pkg::t_in_item          i_in_data,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output mpfu_pkg::t_out_item         o_out_data
);
    import mpfu_pkg::*;

    t_cfg cfg;
    t_job push_job, pop_job;
    logic push, pop, full, empty;

    mpfu_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    mpfu_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (cfg),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .o_push     (push),
        .o_job      (push_job),
        .i_full     (full)
    );

    mpfu_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .o_full  (full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_job   (pop_job)
    );

    mpfu_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_empty     (empty),
        .i_job       (pop_job),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

### rtl/core/mpfu_regs.sv
`timescale 1ns / 1ps
// apb-style configuration registers of the unpacker
// depends on mpfu_pkg

module mpfu_regs (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [mpfu_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready,
    output mpfu_pkg::t_cfg             o_cfg
);
    import mpfu_pkg::*;

    t_cfg       r_cfg;
    logic       wr_en;
    logic [2:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite;
    assign reg_idx = paddr[4:2];
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.bytes_per_pixel <= 3'd4;
            r_cfg.row_width       <= 13'd1;
            r_cfg.row_padding     <= 8'd0;
            r_cfg.red_mask        <= 32'h0000_00FF;
            r_cfg.green_mask      <= 32'h0000_FF00;
            r_cfg.blue_mask       <= 32'h00FF_0000;
            r_cfg.alpha_mask      <= 32'hFF00_0000;
            r_cfg.channel_shifts  <= 20'd803072;
        end else if (wr_en) begin
            case (reg_idx)
                REG_BYTES_PER_PIXEL: r_cfg.bytes_per_pixel <= pwdata[2:0];
                REG_ROW_WIDTH:       r_cfg.row_width       <= pwdata[12:0];
                REG_ROW_PADDING:     r_cfg.row_padding     <= pwdata[7:0];
                REG_RED_MASK:        r_cfg.red_mask        <= pwdata;
                REG_GREEN_MASK:      r_cfg.green_mask      <= pwdata;
                REG_BLUE_MASK:       r_cfg.blue_mask       <= pwdata;
                REG_ALPHA_MASK:      r_cfg.alpha_mask      <= pwdata;
                REG_CHANNEL_SHIFTS:  r_cfg.channel_shifts  <= pwdata[19:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_BYTES_PER_PIXEL: prdata = {29'd0, r_cfg.bytes_per_pixel};
            REG_ROW_WIDTH:       prdata = {19'd0, r_cfg.row_width};
            REG_ROW_PADDING:     prdata = {24'd0, r_cfg.row_padding};
            REG_RED_MASK:        prdata = r_cfg.red_mask;
            REG_GREEN_MASK:      prdata = r_cfg.green_mask;
            REG_BLUE_MASK:       prdata = r_cfg.blue_mask;
            REG_ALPHA_MASK:      prdata = r_cfg.alpha_mask;
            REG_CHANNEL_SHIFTS:  prdata = {12'd0, r_cfg.channel_shifts};
            default:             prdata = 32'd0;
        endcase
    end

endmodule

### rtl/core/mpfu_front.sv
`timescale 1ns / 1ps
// front end: takes raster bytes, assembles pixels, counts columns and padding
// depends on mpfu_pkg

module mpfu_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  mpfu_pkg::t_cfg     i_cfg,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  mpfu_pkg::t_in_item i_in_data,
    output logic               o_push,
    output mpfu_pkg::t_job     o_job,
    input  logic               i_full
);
    import mpfu_pkg::*;

    logic [1:0]  r_pos, n_pos;
    logic [31:0] r_word, n_word;
    logic [11:0] r_col, n_col;
    logic [7:0]  r_pad_left, n_pad_left;
    logic        r_in_pad, n_in_pad;

    logic        accept;
    logic [1:0]  pos;
    logic [31:0] word_in, word;
    logic [11:0] col;
    logic [7:0]  pad_left, pad_dec;
    logic        in_pad;
    logic [2:0]  bpp;
    logic [12:0] width;
    logic        done, last;

    assign o_in_ready = !i_full;
    assign accept     = i_in_valid & o_in_ready;

    // first of frame restarts all counters at this byte
    assign pos      = i_in_data.first_of_frame ? 2'd0  : r_pos;
    assign word_in  = i_in_data.first_of_frame ? 32'd0 : r_word;
    assign col      = i_in_data.first_of_frame ? 12'd0 : r_col;
    assign pad_left = i_in_data.first_of_frame ? 8'd0  : r_pad_left;
    assign in_pad   = i_in_data.first_of_frame ? 1'b0  : r_in_pad;
    assign pad_dec  = pad_left - 8'd1;

    always_comb begin
        case (i_cfg.bytes_per_pixel)
            3'd0:    bpp = 3'd1;
            3'd1:    bpp = 3'd1;
            3'd2:    bpp = 3'd2;
            3'd3:    bpp = 3'd3;
            default: bpp = 3'd4;
        endcase
        if (i_cfg.row_width == 13'd0) begin
            width = 13'd1;
        end else if (i_cfg.row_width > MAX_WIDTH_W) begin
            width = MAX_WIDTH_W;
        end else begin
            width = i_cfg.row_width;
        end
    end

    assign word = (pos == 2'd0) ? {24'd0, i_in_data.data_byte}
                                : word_in | ({24'd0, i_in_data.data_byte} << {pos, 3'b000});
    assign done = !(({1'b0, pos} + 3'd1) < bpp);
    assign last = ({1'b0, col} + 13'd1) >= width;

    assign o_push           = accept & !in_pad & done;
    assign o_job.word       = word;
    assign o_job.mono       = (bpp == 3'd1);
    assign o_job.quad       = (bpp == 3'd4);
    assign o_job.end_of_row = last;

    always_comb begin
        n_pos      = r_pos;
        n_word     = r_word;
        n_col      = r_col;
        n_pad_left = r_pad_left;
        n_in_pad   = r_in_pad;
        if (accept) begin
            n_pos      = pos;
            n_word     = word_in;
            n_col      = col;
            n_pad_left = pad_left;
            n_in_pad   = in_pad;
            if (in_pad) begin
                n_pad_left = pad_dec;
                if (pad_dec == 8'd0) begin
                    n_in_pad = 1'b0;
                end
            end else if (!done) begin
                n_word = word;
                n_pos  = pos + 2'd1;
            end else begin
                n_pos  = 2'd0;
                n_word = 32'd0;
                if (last) begin
                    n_col = 12'd0;
                    if (i_cfg.row_padding != 8'd0) begin
                        n_pad_left = i_cfg.row_padding;
                        n_in_pad   = 1'b1;
                    end
                end else begin
                    n_col = col + 12'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos      <= 2'd0;
            r_word     <= 32'd0;
            r_col      <= 12'd0;
            r_pad_left <= 8'd0;
            r_in_pad   <= 1'b0;
        end else begin
            r_pos      <= n_pos;
            r_word     <= n_word;
            r_col      <= n_col;
            r_pad_left <= n_pad_left;
            r_in_pad   <= n_in_pad;
        end
    end

endmodule

### rtl/core/mpfu_fifo.sv
`timescale 1ns / 1ps
// two-entry queue of assembled pixels between front and back
// depends on mpfu_pkg

module mpfu_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  mpfu_pkg::t_job i_job,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_empty,
    output mpfu_pkg::t_job o_job
);
    import mpfu_pkg::*;

    t_job       r_mem [2];
    logic       r_wr_ptr, r_rd_ptr;
    logic [1:0] r_count;

    assign o_full  = (r_count == 2'd2);
    assign o_empty = (r_count == 2'd0);
    assign o_job   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

### rtl/core/mpfu_back.sv
`timescale 1ns / 1ps
// back end: masked channel extraction into the registered output
// depends on mpfu_pkg

module mpfu_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  mpfu_pkg::t_cfg      i_cfg,
    input  logic                i_empty,
    input  mpfu_pkg::t_job      i_job,
    output logic                o_pop,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output mpfu_pkg::t_out_item o_out_data
);
    import mpfu_pkg::*;

    logic      r_valid;
    t_out_item r_data, n_data;

    function automatic logic [7:0] take_channel(input logic [31:0] word,
                                                input logic [31:0] mask,
                                                input logic [4:0]  sh);
        logic [31:0] t;
        t = (word & mask) >> sh;
        return t[7:0];
    endfunction

    assign o_pop       = !i_empty & (!r_valid | i_out_ready);
    assign o_out_valid = r_valid;
    assign o_out_data  = r_data;

    always_comb begin
        n_data.end_of_row = i_job.end_of_row;
        if (i_job.mono) begin
            n_data.red   = i_job.word[7:0];
            n_data.green = i_job.word[7:0];
            n_data.blue  = i_job.word[7:0];
            n_data.alpha = ALPHA_OPAQUE;
        end else begin
            n_data.red   = take_channel(i_job.word, i_cfg.red_mask,
                                        i_cfg.channel_shifts[4:0]);
            n_data.green = take_channel(i_job.word, i_cfg.green_mask,
                                        i_cfg.channel_shifts[9:5]);
            n_data.blue  = take_channel(i_job.word, i_cfg.blue_mask,
                                        i_cfg.channel_shifts[14:10]);
            n_data.alpha = i_job.quad ? take_channel(i_job.word, i_cfg.alpha_mask,
                                                     i_cfg.channel_shifts[19:15])
                                      : ALPHA_OPAQUE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_data <= n_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_valid <= 1'b0;
        end
    end

endmodule

### rtl/core/mpfu_checker.sv
`timescale 1ns / 1ps
// port-level checks of the unpacker, bound to the top level
// depends on mpfu_pkg and masked_pixel_format_unpacker_core

module mpfu_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        psel,
    input logic                        penable,
    input logic                        pwrite,
    input logic [mpfu_pkg::ADDR_W-1:0] paddr,
    input logic [31:0]                 pwdata,
    input logic [31:0]                 prdata,
    input logic                        o_in_ready,
    input logic                        o_out_valid,
    input logic                        i_out_ready,
    input mpfu_pkg::t_out_item         o_out_data
);
    import mpfu_pkg::*;

    // a stalled result request holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("stalled result changed");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // input only backs up while a result waits at the output
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> o_out_valid)
        else $error("input stalled with empty output");

    a_cfg_readback: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        psel && penable && pwrite && paddr == {REG_BYTES_PER_PIXEL, 2'b00} |=>
            paddr != {REG_BYTES_PER_PIXEL, 2'b00} || prdata[2:0] == $past(pwdata[2:0]))
        else $error("bytes per pixel readback mismatch");

endmodule

bind masked_pixel_format_unpacker_core mpfu_checker u_mpfu_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);
